// ===== src/ypk_pkg.sv =====
// shared types, register indexes and status codes of the planar to uyvy packer
package ypk_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned MAX_ROWS      = 2048;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PAIRS_W   = 13;
  localparam int unsigned ROWS_W    = 12;
  localparam int unsigned ROW_IDX_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_CAPACITY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LENGTH   = 3'd4;

  localparam logic [1:0] STATUS_OK              = 2'd0;
  localparam logic [1:0] STATUS_TARGET_SMALL    = 2'd1;
  localparam logic [1:0] STATUS_SOURCE_MISMATCH = 2'd2;

  typedef struct packed {
    logic [7:0] chroma_red;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] luma_first;
  } in_beat_t;

  typedef struct packed {
    logic        frame_end;
    logic [1:0]  status;
    logic [31:0] target_address;
    logic [31:0] packed_word;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [PAIRS_W-1:0] pairs;
    logic [ROWS_W-1:0]  rows;
    logic               empty;
  } frame_info_t;

  typedef struct packed {
    logic        emit;
    logic        err;
    logic        go;
    logic        odd_row;
    logic        frame_end;
    logic [1:0]  status;
    logic [31:0] address;
  } step_t;

endpackage

// ===== src/ypk_ram.sv =====
// generic single port ram with registered read
module ypk_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ypk_cfg.sv =====
// configuration registers and the derived frame limits and status
module ypk_cfg #(
  parameter int unsigned MAX_WIDTH = ypk_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_i,
  input  logic [ypk_pkg::CFG_IDX_W-1:0]  index_i,
  input  logic [31:0]                    data_i,
  output ypk_pkg::frame_info_t           info_o,
  output logic [15:0]                    stride_o,
  output logic                           busy_o
);

  localparam logic [ypk_pkg::PAIRS_W-1:0] DEPTH_P = ypk_pkg::PAIRS_W'(MAX_WIDTH / 2);
  localparam logic [ypk_pkg::ROWS_W-1:0]  ROWS_P  = ypk_pkg::ROWS_W'(ypk_pkg::MAX_ROWS);

  logic [11:0] width_q, height_q;
  logic [15:0] stride_q;
  logic [31:0] capacity_q, source_q;
  logic [23:0] pixels_q, pixels_d;
  logic [1:0]  settle_q, settle_d;
  ypk_pkg::frame_info_t info_q, info_d;

  logic [24:0] twice_pix;
  logic [24:0] expect_len;
  logic [ypk_pkg::PAIRS_W-1:0] half_w;
  logic [ypk_pkg::ROWS_W-1:0]  even_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= '0;
      height_q   <= '0;
      stride_q   <= '0;
      capacity_q <= '0;
      source_q   <= '0;
    end else if (wr_i) begin
      case (index_i)
        ypk_pkg::REG_FRAME_WIDTH:     width_q    <= data_i[11:0];
        ypk_pkg::REG_FRAME_HEIGHT:    height_q   <= data_i[11:0];
        ypk_pkg::REG_ROW_STRIDE:      stride_q   <= data_i[15:0];
        ypk_pkg::REG_TARGET_CAPACITY: capacity_q <= data_i;
        ypk_pkg::REG_SOURCE_LENGTH:   source_q   <= data_i;
        default: ;
      endcase
    end
  end

  assign pixels_d = 24'(width_q) * 24'(height_q);

  always_comb begin
    twice_pix  = {pixels_q, 1'b0};
    expect_len = 25'(pixels_q) + 25'(pixels_q >> 1);
    half_w     = ypk_pkg::PAIRS_W'(width_q[11:1]);
    even_h     = {height_q[11:1], 1'b0};

    if (capacity_q < 32'(twice_pix)) begin
      info_d.status = ypk_pkg::STATUS_TARGET_SMALL;
    end else if (source_q != 32'(expect_len)) begin
      info_d.status = ypk_pkg::STATUS_SOURCE_MISMATCH;
    end else begin
      info_d.status = ypk_pkg::STATUS_OK;
    end
    info_d.pairs = (half_w > DEPTH_P) ? DEPTH_P : half_w;
    info_d.rows  = (even_h > ROWS_P) ? ROWS_P : even_h;
    info_d.empty = (info_d.pairs == '0) || (info_d.rows == '0);
  end

  // limits are recomputed after a write: product first, then compares
  assign settle_d = wr_i ? 2'd2 : ((settle_q != 2'd0) ? settle_q - 2'd1 : 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixels_q <= '0;
      settle_q <= '0;
      info_q   <= '{status: ypk_pkg::STATUS_OK, pairs: '0, rows: '0, empty: 1'b1};
    end else begin
      pixels_q <= pixels_d;
      settle_q <= settle_d;
      info_q   <= info_d;
    end
  end

  assign info_o   = info_q;
  assign stride_o = stride_q;
  assign busy_o   = (settle_q != 2'd0);

endmodule

// ===== src/ypk_walk.sv =====
// raster position counters and per-beat decision
module ypk_walk #(
  parameter int unsigned COL_W = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  ypk_pkg::frame_info_t info_i,
  input  logic [15:0]          stride_i,
  output ypk_pkg::step_t       step_o,
  output logic [COL_W-1:0]     col_o
);

  logic [COL_W-1:0]              col_q, col_d;
  logic [ypk_pkg::ROW_IDX_W-1:0] row_q, row_d;
  logic [31:0]                   base_q, base_d;
  logic [ypk_pkg::PAIRS_W-1:0]   col_inc;
  logic [ypk_pkg::ROWS_W-1:0]    row_inc;
  logic                          last_col, last_row;

  always_comb begin
    col_inc  = ypk_pkg::PAIRS_W'(col_q) + 1'b1;
    row_inc  = ypk_pkg::ROWS_W'(row_q) + 1'b1;
    // a position at or past the limit counts as the last one
    last_col = (col_inc >= info_i.pairs);
    last_row = (row_inc >= info_i.rows);

    step_o.err       = (info_i.status != ypk_pkg::STATUS_OK);
    step_o.go        = !step_o.err && !info_i.empty;
    step_o.emit      = step_o.err || !info_i.empty;
    step_o.odd_row   = row_q[0];
    step_o.frame_end = last_col && last_row;
    step_o.status    = info_i.status;
    step_o.address   = base_q + {(32 - COL_W - 2)'(0), col_q, 2'b00};

    col_d  = col_q;
    row_d  = row_q;
    base_d = base_q;
    if (accept_i && step_o.go) begin
      if (!last_col) begin
        col_d = col_q + 1'b1;
      end else if (!last_row) begin
        col_d  = '0;
        row_d  = row_q + 1'b1;
        base_d = base_q + 32'(stride_i);
      end else begin
        col_d  = '0;
        row_d  = '0;
        base_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      base_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      base_q <= base_d;
    end
  end

  assign col_o = col_q;

endmodule

// ===== src/yuv420_planar_to_uyvy_packer.sv =====
// top level of the yuv 4:2:0 planar to uyvy 4:2:2 packer
//
// input channel: one luma pair per beat in raster order, with the u/v sample
// of the pair (taken on even rows, written to the chroma line store).
// odd rows reuse the stored chroma of the same column from the line store.
// output channel: one packed word u,y0,v,y1 and its byte address per beat,
// plus a status code and a frame end flag. a bad status gives a beat with
// zero word and address and leaves the position untouched; a frame narrower
// or shorter than one pair gives no beat unless its status is bad.
// the result is registered in stage one (line store read) and then in the
// output register. throughput: one beat per cycle when no stall holds,
// set by the single port line store, which serves one read or one write
// per beat. after each configuration write the input is stalled while
// the frame limits and status are recomputed.
// reset clears the valid flags, configuration and position; the line store and data registers are not cleared.
// a stalled output holds its beat; the stall reaches the input once the
// internal stage is full.
module yuv420_planar_to_uyvy_packer #(
  parameter int unsigned MAX_WIDTH = ypk_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ypk_pkg::in_beat_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ypk_pkg::out_beat_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ypk_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  localparam int unsigned STORE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned COL_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  ypk_pkg::frame_info_t info;
  ypk_pkg::step_t       step;
  logic [15:0]          stride;
  logic                 cfg_busy;
  logic [COL_W-1:0]     col;
  logic                 in_accept, cfg_wr;
  logic                 ram_we, ram_re;
  logic [15:0]          ram_rdata;

  logic        s1_valid_q, s1_valid_d;
  logic        s1_odd_q;
  logic        s1_end_q;
  logic [1:0]  s1_status_q;
  logic [31:0] s1_addr_q;
  logic [7:0]  s1_y0_q, s1_y1_q, s1_u_q, s1_v_q;
  logic        s1_load, s1_adv;

  logic                 out_valid_q, out_valid_d;
  ypk_pkg::out_beat_t   out_q, out_d;
  logic [7:0]           u_sel, v_sel;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  ypk_cfg #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_wr),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .info_o  (info),
    .stride_o(stride),
    .busy_o  (cfg_busy)
  );

  ypk_walk #(
    .COL_W(COL_W)
  ) u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_accept),
    .info_i  (info),
    .stride_i(stride),
    .step_o  (step),
    .col_o   (col)
  );

  assign ram_we = in_accept && step.go && !step.odd_row;
  assign ram_re = in_accept && step.go && step.odd_row;

  ypk_ram #(
    .WIDTH(16),
    .DEPTH(STORE_DEPTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (col),
    .wdata_i({in_data_i.chroma_red, in_data_i.chroma_blue}),
    .rdata_o(ram_rdata)
  );

  // stage one may move on when the output register is free or draining
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign s1_load    = !s1_valid_q || s1_adv;
  assign in_stall_o = cfg_busy || !s1_load;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = s1_load ? (in_accept && step.emit) : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_odd_q    <= step.go && step.odd_row;
      s1_end_q    <= step.go && step.frame_end;
      s1_status_q <= step.status;
      s1_addr_q   <= step.go ? step.address : 32'd0;
      s1_y0_q     <= step.go ? in_data_i.luma_first : 8'd0;
      s1_y1_q     <= step.go ? in_data_i.luma_second : 8'd0;
      s1_u_q      <= step.go ? in_data_i.chroma_blue : 8'd0;
      s1_v_q      <= step.go ? in_data_i.chroma_red : 8'd0;
    end
  end

  always_comb begin
    u_sel = s1_odd_q ? ram_rdata[7:0] : s1_u_q;
    v_sel = s1_odd_q ? ram_rdata[15:8] : s1_v_q;

    out_d.packed_word    = {s1_y1_q, v_sel, s1_y0_q, u_sel};
    out_d.target_address = s1_addr_q;
    out_d.status         = s1_status_q;
    out_d.frame_end      = s1_end_q;

    out_valid_d = s1_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an error beat never carries a word, an address or a frame end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ypk_pkg::STATUS_OK) |->
      (out_data_o.packed_word == 32'd0) && (out_data_o.target_address == 32'd0)
      && !out_data_o.frame_end)
    else $error("error beat with nonzero payload");

  // frame end only on a good beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |-> (out_data_o.status == ypk_pkg::STATUS_OK))
    else $error("frame end on an error beat");

  // limits are being recomputed right after a write, so no input is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> in_stall_o)
    else $error("input taken while limits settle");

  // a blocked stage one keeps its beat and, on odd rows, its line store data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_addr_q)
      && (!s1_odd_q || $stable(ram_rdata)))
    else $error("stage one lost its beat under stall");

  // the line store serves one access per beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("line store read and write together");

endmodule
